// ===== hdl/i2c_master_register_access_defines.svh =====
// ----------------------------------------------------------------------------
// i2c master register access assertion macros
// shared assertion helpers for the register access block
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH

// clocked assertion with explicit clock and reset
`define I2CRA_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion on the default clock and reset names
`define I2CRA_ASSERT(lbl, prop, msg) \
  `I2CRA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/i2cra_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cra_pkg
// types and constants for the i2c master register access block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cra_pkg;

  localparam logic [1:0] MODE_WR8  = 2'd0;
  localparam logic [1:0] MODE_WR16 = 2'd1;
  localparam logic [1:0] MODE_RD8  = 2'd2;
  localparam logic [1:0] MODE_RD16 = 2'd3;

  typedef struct packed {
    logic        start_cmd;
    logic [1:0]  mode;
    logic [6:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [15:0] write_data;
    logic        sda_level;
  } item_t;

  typedef struct packed {
    logic        scl_drive;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic        nack_error;
    logic [15:0] read_data;
  } result_t;

  // bytes on the bus per transaction kind
  function automatic logic [2:0] total_bytes(input logic [1:0] mode);
    logic [2:0] n;
    case (mode)
      MODE_WR8:  n = 3'd3;
      MODE_WR16: n = 3'd4;
      MODE_RD8:  n = 3'd4;
      MODE_RD16: n = 3'd5;
      default:   n = 3'd3;
    endcase
    return n;
  endfunction

  function automatic logic is_read(input logic [1:0] mode);
    return (mode == MODE_RD8) || (mode == MODE_RD16);
  endfunction

endpackage

// ===== hdl/i2cra_fifo.sv =====
// ----------------------------------------------------------------------------
// i2cra_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cra_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             wr, rd;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign wr      = push_i & ~full_o;
  assign rd      = pop_i & ~empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (wr) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (wr && !rd) begin
      count_d = count_q + 1'b1;
    end else if (rd && !wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/i2cra_engine.sv =====
// ----------------------------------------------------------------------------
// i2cra_engine
// bus phase sequencer, one phase per tick item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_master_register_access_defines.svh"

module i2cra_engine
  import i2cra_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  input  logic    res_space_i,
  output logic    fire_o,
  output result_t res_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_BITLO, PH_BITHI, PH_ACKLO, PH_ACKHI,
    PH_RSA, PH_RSB, PH_RSC, PH_STOPA, PH_STOPB
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  bit_count_q, bit_count_d;
  logic [2:0]  byte_index_q, byte_index_d;
  logic [7:0]  shift_byte_q, shift_byte_d;
  logic [1:0]  mode_q, mode_d;
  logic [6:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d;
  logic [15:0] data_q, data_d;
  logic [15:0] read_word_q, read_word_d;
  logic        error_q, error_d;
  logic        done;
  logic        rx_now, rx_next;
  logic [2:0]  nxt_index;

  assign fire_o = item_valid_i & res_space_i;

  function automatic logic [7:0] load_byte(input logic [2:0]  idx,
                                           input logic [1:0]  mode,
                                           input logic [6:0]  dev,
                                           input logic [7:0]  rga,
                                           input logic [15:0] dat);
    logic [7:0] v;
    v = 8'h00;
    if (idx == 3'd0) begin
      v = {dev, 1'b0};
    end else if (idx == 3'd1) begin
      v = rga;
    end else if (idx == 3'd2) begin
      if (is_read(mode)) v = {dev, 1'b1};
      else if (mode == MODE_WR16) v = dat[15:8];
      else v = dat[7:0];
    end else if (!is_read(mode)) begin
      v = dat[7:0];
    end
    return v;
  endfunction

  always_comb begin
    phase_d      = phase_q;
    bit_count_d  = bit_count_q;
    byte_index_d = byte_index_q;
    shift_byte_d = shift_byte_q;
    mode_d       = mode_q;
    dev_d        = dev_q;
    reg_d        = reg_q;
    data_d       = data_q;
    read_word_d  = read_word_q;
    error_d      = error_q;
    done         = 1'b0;
    nxt_index    = byte_index_q + 3'd1;
    rx_now       = is_read(mode_q) && (byte_index_q >= 3'd3);
    if (fire_o) begin
      case (phase_q)
        PH_IDLE: begin
          if (item_i.start_cmd) begin
            mode_d       = item_i.mode;
            dev_d        = item_i.dev_addr;
            reg_d        = item_i.reg_addr;
            data_d       = item_i.write_data;
            error_d      = 1'b0;
            byte_index_d = 3'd0;
            bit_count_d  = 4'd0;
            shift_byte_d = 8'h00;
            phase_d      = PH_START;
          end
        end
        PH_START, PH_RSC: begin
          shift_byte_d = load_byte(byte_index_q, mode_q, dev_q, reg_q, data_q);
          bit_count_d  = 4'd0;
          phase_d      = PH_BITLO;
        end
        PH_BITLO: phase_d = PH_BITHI;
        PH_BITHI: begin
          shift_byte_d = {shift_byte_q[6:0], rx_now & item_i.sda_level};
          bit_count_d  = bit_count_q + 4'd1;
          phase_d      = (bit_count_d >= 4'd8) ? PH_ACKLO : PH_BITLO;
        end
        PH_ACKLO: phase_d = PH_ACKHI;
        PH_ACKHI: begin
          if (!rx_now && item_i.sda_level) begin
            error_d = 1'b1;
            phase_d = PH_STOPA;
          end else begin
            if (rx_now) begin
              if (byte_index_q == 3'd3) begin
                read_word_d = (mode_q == MODE_RD16) ? {shift_byte_q, 8'h00}
                                                    : {8'h00, shift_byte_q};
              end else begin
                read_word_d = {read_word_q[15:8], shift_byte_q};
              end
            end
            byte_index_d = nxt_index;
            if (nxt_index >= total_bytes(mode_q)) begin
              phase_d = PH_STOPA;
            end else if (is_read(mode_q) && nxt_index == 3'd2) begin
              phase_d = PH_RSA;
            end else begin
              shift_byte_d = load_byte(nxt_index, mode_q, dev_q, reg_q, data_q);
              bit_count_d  = 4'd0;
              phase_d      = PH_BITLO;
            end
          end
        end
        PH_RSA:   phase_d = PH_RSB;
        PH_RSB:   phase_d = PH_RSC;
        PH_STOPA: phase_d = PH_STOPB;
        PH_STOPB: begin
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
        default:  phase_d = PH_IDLE;
      endcase
    end

    rx_next           = is_read(mode_d) && (byte_index_d >= 3'd3);
    res_o.busy_res    = (phase_d != PH_IDLE);
    res_o.done_res    = done;
    res_o.nack_error  = error_d;
    res_o.read_data   = read_word_d;
    case (phase_d)
      PH_START: begin
        res_o.scl_drive = 1'b1;
        res_o.sda_drive = 1'b0;
      end
      PH_BITLO, PH_BITHI: begin
        res_o.scl_drive = (phase_d == PH_BITHI);
        res_o.sda_drive = rx_next | shift_byte_d[7];
      end
      PH_ACKLO, PH_ACKHI: begin
        res_o.scl_drive = (phase_d == PH_ACKHI);
        res_o.sda_drive = !(rx_next && ((byte_index_d + 3'd1) < total_bytes(mode_d)));
      end
      PH_RSA: begin
        res_o.scl_drive = 1'b0;
        res_o.sda_drive = 1'b1;
      end
      PH_RSC, PH_STOPB: begin
        res_o.scl_drive = 1'b1;
        res_o.sda_drive = 1'b0;
      end
      PH_STOPA: begin
        res_o.scl_drive = 1'b0;
        res_o.sda_drive = 1'b0;
      end
      default: begin
        res_o.scl_drive = 1'b1;
        res_o.sda_drive = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bit_count_q  <= '0;
      byte_index_q <= '0;
      shift_byte_q <= '0;
      mode_q       <= '0;
      dev_q        <= '0;
      reg_q        <= '0;
      data_q       <= '0;
      read_word_q  <= '0;
      error_q      <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      bit_count_q  <= bit_count_d;
      byte_index_q <= byte_index_d;
      shift_byte_q <= shift_byte_d;
      mode_q       <= mode_d;
      dev_q        <= dev_d;
      reg_q        <= reg_d;
      data_q       <= data_d;
      read_word_q  <= read_word_d;
      error_q      <= error_d;
    end
  end

  `I2CRA_ASSERT(a_bitcnt_range, bit_count_q <= 4'd8, "bit counter past eight")
  `I2CRA_ASSERT(a_stop_done, (fire_o && phase_q == PH_STOPB) |-> res_o.done_res, "stop without done")
  `I2CRA_ASSERT(a_idle_hold, (fire_o && phase_q == PH_IDLE && !item_i.start_cmd) |=> (phase_q == PH_IDLE), "left idle without start")
  `I2CRA_ASSERT(a_index_range, byte_index_q <= 3'd5, "byte index out of range")

endmodule

// ===== hdl/i2c_master_register_access.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_access
// i2c master running register read and write transactions, one bus phase
// per tick item, with queues on both sides of the phase sequencer
// ----------------------------------------------------------------------------
// channel   direction  handshake         payload
// tick      in         push / full       item_i   (item_t)
// result    out        pop / empty       result_o (result_t)
//
// one result per tick item; the sequencer takes one item per cycle while the
// tick queue holds an item and the result queue has room (both registered)
// reset clears both queues and returns the sequencer to idle, lines released
// a stalled result side fills the result queue, then the tick queue, then full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_register_access
  import i2cra_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  input  item_t   item_i,
  output logic    full,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  item_t   item_q;
  logic    item_empty;
  logic    res_full;
  logic    fire;
  result_t res;

  i2cra_fifo #(
    .Depth (QueueDepth),
    .Width ($bits(item_t))
  ) u_in_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item_i),
    .full_o  (full),
    .pop_i   (fire),
    .data_o  (item_q),
    .empty_o (item_empty)
  );

  i2cra_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (~item_empty),
    .item_i       (item_q),
    .res_space_i  (~res_full),
    .fire_o       (fire),
    .res_o        (res)
  );

  i2cra_fifo #(
    .Depth (QueueDepth),
    .Width ($bits(result_t))
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

// ===== dv/i2cra_bus_checker.sv =====
// ----------------------------------------------------------------------------
// i2cra_bus_checker
// watches the tick and result queues of the i2c master, runs its own model of
// the bus phase sequencer on every accepted tick and compares every popped
// result against the oldest predicted one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cra_bus_checker
  import i2cra_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  input  logic    full,
  input  item_t   item_i,
  input  logic    pop,
  input  logic    empty,
  input  result_t result_i,
  output int      mismatch_count,
  output int      pending_count
);

  typedef enum logic [4:0] {
    BUS_IDLE,
    BUS_START,
    BIT_LOW,
    BIT_HIGH,
    ACK_LOW,
    ACK_HIGH,
    RESTART_A,
    RESTART_B,
    RESTART_C,
    STOP_A,
    STOP_B
  } bus_phase_e;

  bus_phase_e  phase_q;
  logic [3:0]  bit_cnt_q;
  logic [2:0]  byte_idx_q;
  logic [7:0]  shift_q;
  logic [1:0]  cmd_mode_q;
  logic [6:0]  cmd_dev_q;
  logic [7:0]  cmd_reg_q;
  logic [15:0] cmd_data_q;
  logic [15:0] read_word_q;
  logic        error_q;

  result_t expected_bus_levels[$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  function automatic logic [2:0] frame_length(input logic [1:0] m);
    logic [2:0] n;
    case (m)
      MODE_WR8:  n = 3'd3;
      MODE_WR16: n = 3'd4;
      MODE_RD8:  n = 3'd4;
      default:   n = 3'd5;
    endcase
    return n;
  endfunction

  function automatic logic cmd_reads();
    return (cmd_mode_q == MODE_RD8) || (cmd_mode_q == MODE_RD16);
  endfunction

  function automatic logic receiving();
    return cmd_reads() && (byte_idx_q >= 3'd3);
  endfunction

  function automatic logic final_byte();
    return ({1'b0, byte_idx_q} + 4'd1) >= {1'b0, frame_length(cmd_mode_q)};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic reset_bus_model();
    phase_q     = BUS_IDLE;
    bit_cnt_q   = '0;
    byte_idx_q  = '0;
    shift_q     = '0;
    cmd_mode_q  = MODE_WR8;
    cmd_dev_q   = '0;
    cmd_reg_q   = '0;
    cmd_data_q  = '0;
    read_word_q = '0;
    error_q     = 1'b0;
  endtask

  task automatic load_shift();
    logic [7:0] v;
    v = '0;
    bit_cnt_q = '0;
    case (byte_idx_q)
      3'd0: v = {cmd_dev_q, 1'b0};
      3'd1: v = cmd_reg_q;
      3'd2: begin
        if (cmd_reads()) v = {cmd_dev_q, 1'b1};
        else if (cmd_mode_q == MODE_WR16) v = cmd_data_q[15:8];
        else v = cmd_data_q[7:0];
      end
      default: begin
        if (!cmd_reads()) v = cmd_data_q[7:0];
      end
    endcase
    shift_q = v;
  endtask

  task automatic advance_byte();
    byte_idx_q = byte_idx_q + 3'd1;
    if (byte_idx_q >= frame_length(cmd_mode_q)) begin
      phase_q = STOP_A;
    end else if (cmd_reads() && byte_idx_q == 3'd2) begin
      phase_q = RESTART_A;
    end else begin
      load_shift();
      phase_q = BIT_LOW;
    end
  endtask

  task automatic step_bus_phase(input item_t t, output result_t r);
    logic scl;
    logic sda;
    logic done;
    scl  = 1'b1;
    sda  = 1'b1;
    done = 1'b0;

    case (phase_q)
      BUS_IDLE: begin
        if (t.start_cmd) begin
          cmd_mode_q = t.mode;
          cmd_dev_q  = t.dev_addr;
          cmd_reg_q  = t.reg_addr;
          cmd_data_q = t.write_data;
          error_q    = 1'b0;
          byte_idx_q = '0;
          bit_cnt_q  = '0;
          shift_q    = '0;
          phase_q    = BUS_START;
        end
      end
      BUS_START, RESTART_C: begin
        load_shift();
        phase_q = BIT_LOW;
      end
      BIT_LOW: phase_q = BIT_HIGH;
      BIT_HIGH: begin
        shift_q   = {shift_q[6:0], receiving() ? t.sda_level : 1'b0};
        bit_cnt_q = bit_cnt_q + 4'd1;
        phase_q   = (bit_cnt_q >= 4'd8) ? ACK_LOW : BIT_LOW;
      end
      ACK_LOW: phase_q = ACK_HIGH;
      ACK_HIGH: begin
        if (receiving()) begin
          if (byte_idx_q == 3'd3) begin
            if (cmd_mode_q == MODE_RD16) read_word_q = {shift_q, 8'h00};
            else read_word_q = {8'h00, shift_q};
          end else begin
            read_word_q = {read_word_q[15:8], shift_q};
          end
          advance_byte();
        end else if (t.sda_level) begin
          error_q = 1'b1;
          phase_q = STOP_A;
        end else begin
          advance_byte();
        end
      end
      RESTART_A: phase_q = RESTART_B;
      RESTART_B: phase_q = RESTART_C;
      STOP_A:    phase_q = STOP_B;
      STOP_B: begin
        phase_q = BUS_IDLE;
        done    = 1'b1;
      end
      default: phase_q = BUS_IDLE;
    endcase

    case (phase_q)
      BUS_START: begin
        scl = 1'b1;
        sda = 1'b0;
      end
      BIT_LOW, BIT_HIGH: begin
        scl = (phase_q == BIT_HIGH);
        sda = receiving() ? 1'b1 : shift_q[7];
      end
      ACK_LOW, ACK_HIGH: begin
        scl = (phase_q == ACK_HIGH);
        sda = (receiving() && !final_byte()) ? 1'b0 : 1'b1;
      end
      RESTART_A: begin
        scl = 1'b0;
        sda = 1'b1;
      end
      RESTART_B: begin
        scl = 1'b1;
        sda = 1'b1;
      end
      RESTART_C: begin
        scl = 1'b1;
        sda = 1'b0;
      end
      STOP_A: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      STOP_B: begin
        scl = 1'b1;
        sda = 1'b0;
      end
      default: begin
        scl = 1'b1;
        sda = 1'b1;
      end
    endcase

    r.scl_drive  = scl;
    r.sda_drive  = sda;
    r.busy_res   = (phase_q != BUS_IDLE);
    r.done_res   = done;
    r.nack_error = error_q;
    r.read_data  = read_word_q;
  endtask

  always @(posedge clk_i) begin : monitor
    result_t want;
    result_t predicted;
    if (!rst_ni) begin
      reset_bus_model();
      expected_bus_levels.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_bus_levels.size() == 0) begin
          report_mismatch("result popped with no transaction pending");
        end else begin
          want = expected_bus_levels.pop_front();
          if (result_i.scl_drive !== want.scl_drive)
            report_mismatch($sformatf("scl_drive got %b want %b",
                                      result_i.scl_drive, want.scl_drive));
          if (result_i.sda_drive !== want.sda_drive)
            report_mismatch($sformatf("sda_drive got %b want %b",
                                      result_i.sda_drive, want.sda_drive));
          if (result_i.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res got %b want %b",
                                      result_i.busy_res, want.busy_res));
          if (result_i.done_res !== want.done_res)
            report_mismatch($sformatf("done_res got %b want %b",
                                      result_i.done_res, want.done_res));
          if (result_i.nack_error !== want.nack_error)
            report_mismatch($sformatf("nack_error got %b want %b",
                                      result_i.nack_error, want.nack_error));
          if (result_i.read_data !== want.read_data)
            report_mismatch($sformatf("read_data got %h want %h",
                                      result_i.read_data, want.read_data));
        end
      end
      if (push && !full) begin
        step_bus_phase(item_i, predicted);
        expected_bus_levels.push_back(predicted);
      end
    end
    pending_count <= expected_bus_levels.size();
  end

endmodule

// ===== dv/tb_i2c_master_register_access.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_master_register_access
// drives bus phase ticks into the i2c master as whole register transactions
// with random content, acks and nacks placed on the sampling ticks, random
// idling on both queues, a long result stall and a full drain; the checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_i2c_master_register_access
  import i2cra_pkg::*;
();

  localparam int ClockPeriod   = 12;
  localparam int CycleLimit    = 400000;
  localparam int RandomTicks   = 420;
  localparam int QuietTail     = 100;
  localparam int HoldOffCycles = 400;

  logic    clk_i;
  logic    rst_ni;
  logic    push;
  logic    full;
  logic    empty;
  logic    pop;
  item_t   tick_item;
  result_t bus_levels;

  int mismatch_count;
  int pending_count;

  bit     idling_on;
  bit     hold_off_req;
  int     ticks_sent;
  int     quiet_from;
  int     txn_per_mode[4];
  int     nack_txns;
  int     cycle_count;
  item_t  tick_plan[$];

  i2c_master_register_access uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .item_i   (tick_item),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .result_o (bus_levels)
  );

  i2cra_bus_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .item_i         (tick_item),
    .pop            (pop),
    .empty          (empty),
    .result_i       (bus_levels),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClockPeriod / 2) clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic item_t noise_tick();
    item_t t;
    t.start_cmd  = 1'($urandom_range(0, 1));
    t.mode       = 2'($urandom_range(0, 3));
    t.dev_addr   = 7'($urandom_range(0, 127));
    t.reg_addr   = 8'($urandom_range(0, 255));
    t.write_data = 16'($urandom_range(0, 65535));
    t.sda_level  = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // lays out every tick of one transaction; the ack tick of each sent byte
  // carries the ack or the nack, the first tick carries the command and all other ticks carry random fields
  task automatic plan_transaction(input logic [1:0] mode, input logic [6:0] dev,
                                  input logic [7:0] rega, input logic [15:0] wdata,
                                  input int nack_at);
    item_t t;
    int    nbytes;
    logic  rd;
    rd = (mode == MODE_RD8) || (mode == MODE_RD16);
    case (mode)
      MODE_WR8:  nbytes = 3;
      MODE_WR16: nbytes = 4;
      MODE_RD8:  nbytes = 4;
      default:   nbytes = 5;
    endcase
    t = noise_tick();
    t.start_cmd  = 1'b1;
    t.mode       = mode;
    t.dev_addr   = dev;
    t.reg_addr   = rega;
    t.write_data = wdata;
    tick_plan.push_back(t);
    tick_plan.push_back(noise_tick());
    for (int b = 0; b < nbytes; b++) begin
      if (rd && b == 2) repeat (3) tick_plan.push_back(noise_tick());
      repeat (17) tick_plan.push_back(noise_tick());
      t = noise_tick();
      if (!rd || b < 3) t.sda_level = (b == nack_at);
      tick_plan.push_back(t);
      if (b == nack_at) break;
    end
    repeat (2) tick_plan.push_back(noise_tick());
    repeat ($urandom_range(0, 3)) begin
      t = noise_tick();
      t.start_cmd = 1'b0;
      tick_plan.push_back(t);
    end
    txn_per_mode[mode]++;
    if (nack_at >= 0) nack_txns++;
  endtask

  task automatic drive_plan();
    while (tick_plan.size() != 0) begin
      if (idling_on && $urandom_range(0, 7) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      push      <= 1'b1;
      tick_item <= tick_plan.pop_front();
      @(posedge clk_i);
      while (full) @(posedge clk_i);
      ticks_sent++;
      if (ticks_sent >= quiet_from) idling_on = 1'b0;
    end
  endtask

  initial begin : result_side
    pop <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_off_req) begin
        pop <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [1:0] mode;
    int         nack_at;
    int         random_start;
    bit         hold_done;
    rst_ni       <= 1'b0;
    push         <= 1'b0;
    tick_item    <= '0;
    idling_on    = 1'b1;
    hold_off_req = 1'b0;
    hold_done    = 1'b0;
    ticks_sent   = 0;
    quiet_from   = 1 << 30;
    nack_txns    = 0;
    foreach (txn_per_mode[i]) txn_per_mode[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every mode, address and data extremes, nack on each sent
    // byte position, aborted read, error flag cleared by the next transaction
    plan_transaction(MODE_WR8,  7'h00, 8'h00, 16'hFFFF, -1);
    plan_transaction(MODE_WR16, 7'h7F, 8'hFF, 16'hA55A, -1);
    plan_transaction(MODE_RD16, 7'h55, 8'h80, 16'h0000, -1);
    plan_transaction(MODE_RD8,  7'h2A, 8'h01, 16'h8001, -1);
    plan_transaction(MODE_WR16, 7'h01, 8'h7F, 16'hFF00, 3);
    plan_transaction(MODE_RD16, 7'h40, 8'h10, 16'h00FF, 2);
    plan_transaction(MODE_WR8,  7'h7F, 8'hFF, 16'h0080, 0);
    plan_transaction(MODE_RD8,  7'h00, 8'hFF, 16'hFFFF, 1);
    plan_transaction(MODE_WR16, 7'h3C, 8'h5A, 16'h1234, 2);
    plan_transaction(MODE_WR8,  7'h7F, 8'hFF, 16'h0000, -1);
    drive_plan();
    push <= 1'b0;

    // sender pause until the result side has drained
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);

    random_start = ticks_sent;
    quiet_from   = ticks_sent + RandomTicks - QuietTail;
    while (ticks_sent - random_start < RandomTicks) begin
      mode    = 2'($urandom_range(0, 3));
      nack_at = -1;
      if ($urandom_range(0, 4) == 0)
        nack_at = int'($urandom_range(0, (mode == MODE_WR16) ? 3 : 2));
      plan_transaction(mode, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)), nack_at);
      if (!hold_done && ticks_sent - random_start > 150) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      drive_plan();
    end
    push <= 1'b0;

    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d byte writes, %0d word writes, %0d byte reads, %0d word reads",
             txn_per_mode[MODE_WR8], txn_per_mode[MODE_WR16],
             txn_per_mode[MODE_RD8], txn_per_mode[MODE_RD16]);
    $display("%0d transactions aborted on nack, %0d ticks, %0d mismatches",
             nack_txns, ticks_sent, mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/i2cra_pkg.sv
hdl/i2cra_fifo.sv
hdl/i2cra_engine.sv
hdl/i2c_master_register_access.sv
dv/i2cra_bus_checker.sv
dv/tb_i2c_master_register_access.sv
